// File: hw/rtl/planar_rle_plane_decoder_top_macros.svh
// assertion macros for the planar rle plane decoder checker
// depends on signals named clk and rst_n in the scope of use
`ifndef PLANAR_RLE_PLANE_DECODER_TOP_MACROS_SVH
`define PLANAR_RLE_PLANE_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PRPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prpd check failed");

// next-cycle implication, disabled while in reset
`define PRPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prpd check failed");

`endif

// File: hw/rtl/prpd_pkg.sv
// shared types and constants of the planar rle plane decoder
// no dependencies
`default_nettype none

package prpd_pkg;

  localparam int PIX_W  = 8;
  localparam int POS_W  = 12;
  localparam int CNT_W  = 13;
  localparam int RAW_W  = 4;
  localparam int RUN_W  = 6;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP   = 2'd2;

  // long-run control codes in the run nibble and their base lengths
  localparam logic [RAW_W-1:0] RUN_CODE_16 = 4'd1;
  localparam logic [RAW_W-1:0] RUN_CODE_32 = 4'd2;
  localparam logic [RUN_W-1:0] RUN_BASE_16 = 6'd16;
  localparam logic [RUN_W-1:0] RUN_BASE_32 = 6'd32;

  // one sample command from the sequencer to the pixel stage
  typedef struct packed {
    logic             err;
    logic             row0;
    logic [PIX_W-1:0] delta;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             burst_last;
    logic             plane_done;
  } sample_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/prpd_seq.sv
// byte sequencer: control byte decode, raw and run counters, position tracking
// depends on prpd_pkg
`default_nettype none

module prpd_seq
  import prpd_pkg::*;
#(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PIX_W-1:0]  in_byte,
  input  wire logic [CNT_W-1:0]  eff_w,
  input  wire logic [CNT_W-1:0]  eff_h,
  input  wire logic              flip,
  input  wire logic              slot_free,
  output logic                   issue,
  output sample_cmd_t            cmd,
  output logic [ADDR_W-1:0]      addr
);

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [RAW_W-1:0] raw_rem_r, raw_rem_nxt;
  logic [RUN_W-1:0] run_pend_r, run_pend_nxt;
  logic             run_act_r, run_act_nxt;
  logic [PIX_W-1:0] last_r, last_nxt;

  logic             acc, data_mode, do_raw, do_run, do_err, samp, ovr;
  logic [RAW_W-1:0] ctl_raw;
  logic [RUN_W-1:0] ctl_run;
  logic [PIX_W-1:0] zz, lv_new;
  logic [CNT_W-1:0] col_inc, row_inc, rep_full;
  logic             wrap, done, samp_last, row0;

  // handshake and what this cycle does
  assign in_ready  = !run_act_r && slot_free;
  assign acc       = in_valid && in_ready;
  assign data_mode = (raw_rem_r != '0);
  assign do_raw    = acc && data_mode;
  assign do_run    = run_act_r && slot_free;
  assign do_err    = acc && !data_mode && ovr;
  assign samp      = do_raw || do_run;
  assign issue     = samp || do_err;

  // control byte decode, long runs carry no raw bytes
  always_comb begin
    ctl_raw = in_byte[7:4];
    ctl_run = RUN_W'(in_byte[3:0]);
    if (in_byte[3:0] == RUN_CODE_16) begin
      ctl_run = RUN_BASE_16 + RUN_W'(in_byte[7:4]);
      ctl_raw = '0;
    end else if (in_byte[3:0] == RUN_CODE_32) begin
      ctl_run = RUN_BASE_32 + RUN_W'(in_byte[7:4]);
      ctl_raw = '0;
    end
  end

  assign ovr = ((CNT_W+1)'(col_r) + (CNT_W+1)'(ctl_raw) + (CNT_W+1)'(ctl_run))
               > (CNT_W+1)'(eff_w);

  // zigzag delta: even b gives b/2, odd b gives -(b/2+1)
  assign zz     = in_byte[0] ? ~{1'b0, in_byte[7:1]} : {1'b0, in_byte[7:1]};
  assign row0   = (row_r == '0);
  assign lv_new = do_raw ? (row0 ? in_byte : zz) : last_r;

  // position advance
  assign col_inc  = col_r + CNT_W'(1);
  assign row_inc  = row_r + CNT_W'(1);
  assign wrap     = (col_inc >= eff_w);
  assign done     = wrap && (row_inc >= eff_h);
  assign rep_full = eff_h - CNT_W'(1) - row_r;
  // a raw byte closes its item unless it is the last one and a run follows
  assign samp_last = do_raw ? !((raw_rem_r == RAW_W'(1)) && (run_pend_r != '0))
                            : (run_pend_r == RUN_W'(1));

  // sample command
  always_comb begin
    cmd = '0;
    if (do_err) begin
      cmd.err        = 1'b1;
      cmd.burst_last = 1'b1;
    end else begin
      cmd.row0       = row0;
      cmd.delta      = lv_new;
      cmd.col        = col_r[POS_W-1:0];
      cmd.row        = flip ? rep_full[POS_W-1:0] : row_r[POS_W-1:0];
      cmd.burst_last = samp_last;
      cmd.plane_done = done;
    end
  end

  assign addr = ADDR_W'(col_r);

  // next state
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    raw_rem_nxt  = raw_rem_r;
    run_pend_nxt = run_pend_r;
    run_act_nxt  = run_act_r;
    last_nxt     = last_r;
    if (samp) begin
      if (wrap) begin
        col_nxt  = '0;
        last_nxt = '0;
        row_nxt  = done ? '0 : row_inc;
      end else begin
        col_nxt  = col_inc;
        last_nxt = lv_new;
      end
    end
    if (do_raw) begin
      raw_rem_nxt = raw_rem_r - RAW_W'(1);
      if ((raw_rem_r == RAW_W'(1)) && (run_pend_r != '0)) begin
        run_act_nxt = 1'b1;
      end
    end
    if (do_run) begin
      run_pend_nxt = run_pend_r - RUN_W'(1);
      if (run_pend_r == RUN_W'(1)) begin
        run_act_nxt = 1'b0;
      end
    end
    if (acc && !data_mode) begin
      if (ovr) begin
        col_nxt      = '0;
        row_nxt      = '0;
        raw_rem_nxt  = '0;
        run_pend_nxt = '0;
        run_act_nxt  = 1'b0;
        last_nxt     = '0;
      end else if (ctl_raw != '0) begin
        raw_rem_nxt  = ctl_raw;
        run_pend_nxt = ctl_run;
      end else begin
        run_pend_nxt = ctl_run;
        run_act_nxt  = (ctl_run != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      raw_rem_r  <= '0;
      run_pend_r <= '0;
      run_act_r  <= 1'b0;
      last_r     <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      raw_rem_r  <= raw_rem_nxt;
      run_pend_r <= run_pend_nxt;
      run_act_r  <= run_act_nxt;
      last_r     <= last_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/prpd_pix.sv
// pixel stage: line store read-modify-write with forwarding, output register
// depends on prpd_pkg
`default_nettype none

module prpd_pix
  import prpd_pkg::*;
#(
  parameter int ADDR_W = 12,
  parameter int DEPTH  = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              issue,
  input  sample_cmd_t            cmd,
  input  wire logic [ADDR_W-1:0] addr,
  output logic                   slot_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       out_pixel_value,
  output logic [POS_W-1:0]       out_column,
  output logic [POS_W-1:0]       out_row,
  output logic                   out_burst_last,
  output logic                   out_plane_done,
  output logic                   out_overrun_error
);

  logic [PIX_W-1:0] line_mem [DEPTH];

  logic              s1_valid_r;
  sample_cmd_t       s1_cmd_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [PIX_W-1:0]  rd_data_r;
  logic              fwd_r;
  logic [PIX_W-1:0]  fwd_data_r;
  logic              out_valid_r;

  logic              adv, wr_en;
  logic [PIX_W-1:0]  above, v;

  assign adv       = !out_valid_r || out_ready;
  assign slot_free = !s1_valid_r || adv;
  assign wr_en     = s1_valid_r && adv && !s1_cmd_r.err;

  // pixel above, taking a write that raced the read
  assign above = fwd_r ? fwd_data_r : rd_data_r;
  assign v     = s1_cmd_r.err ? '0 : (s1_cmd_r.row0 ? s1_cmd_r.delta : above + s1_cmd_r.delta);

  // line store: read on issue, write back on completion
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r  <= line_mem[addr];
      fwd_r      <= wr_en && (s1_addr_r == addr);
      fwd_data_r <= v;
    end
    if (wr_en) begin
      line_mem[s1_addr_r] <= v;
    end
  end

  // stage one: command waiting for its read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (slot_free) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_cmd_r  <= cmd;
      s1_addr_r <= addr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      out_pixel_value   <= v;
      out_column        <= s1_cmd_r.col;
      out_row           <= s1_cmd_r.row;
      out_burst_last    <= s1_cmd_r.burst_last;
      out_plane_done    <= s1_cmd_r.plane_done;
      out_overrun_error <= s1_cmd_r.err;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/planar_rle_plane_decoder_top.sv
// planar rle plane decoder top level: configuration registers and clamps
// depends on prpd_pkg, prpd_seq, prpd_pix
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    in_byte
//   out       output     out_valid/out_ready  pixel_value column row flags
//   cfg       input      cfg_wr_en            cfg_index cfg_wdata
//
// at most one sample leaves per cycle while the output is not stalled, set by the
// single line store port pair; a run holds the input while its samples are issued
// issue reaches out_valid via stage one (memory read), then the output register
// reset is synchronous; the line store is not cleared and holds the row above
// a stalled output holds the pipeline and then the input
`default_nettype none

module planar_rle_plane_decoder_top
  import prpd_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     in_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_pixel_value,
  output logic [POS_W-1:0]          out_column,
  output logic [POS_W-1:0]          out_row,
  output logic                      out_burst_last,
  output logic                      out_plane_done,
  output logic                      out_overrun_error,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);
  localparam logic [16:0] MaxH = 17'(MAX_HEIGHT);

  logic [CNT_W-1:0] width_r, height_r;
  logic             flip_r;
  logic [CNT_W-1:0] eff_w, eff_h;

  logic              slot_free, issue;
  sample_cmd_t       cmd;
  logic [ADDR_W-1:0] addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CNT_W'(64);
      height_r <= CNT_W'(64);
      flip_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        CFG_FLIP:   flip_r   <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // clamp to 1..max
  always_comb begin
    eff_w = width_r;
    if (width_r == '0) begin
      eff_w = CNT_W'(1);
    end else if (17'(width_r) > MaxW) begin
      eff_w = CNT_W'(MaxW);
    end
    eff_h = height_r;
    if (height_r == '0) begin
      eff_h = CNT_W'(1);
    end else if (17'(height_r) > MaxH) begin
      eff_h = CNT_W'(MaxH);
    end
  end

  prpd_seq #(
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .flip      (flip_r),
    .slot_free (slot_free),
    .issue     (issue),
    .cmd       (cmd),
    .addr      (addr)
  );

  prpd_pix #(
    .ADDR_W (ADDR_W),
    .DEPTH  (MAX_WIDTH)
  ) u_pix (
    .clk               (clk),
    .rst_n             (rst_n),
    .issue             (issue),
    .cmd               (cmd),
    .addr              (addr),
    .slot_free         (slot_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_value   (out_pixel_value),
    .out_column        (out_column),
    .out_row           (out_row),
    .out_burst_last    (out_burst_last),
    .out_plane_done    (out_plane_done),
    .out_overrun_error (out_overrun_error)
  );

endmodule

`default_nettype wire

// File: hw/rtl/prpd_chk.sv
// port-level checker for the planar rle plane decoder, bound to the top level
// depends on prpd_pkg and planar_rle_plane_decoder_top_macros.svh
`default_nettype none
`include "planar_rle_plane_decoder_top_macros.svh"

module prpd_chk
  import prpd_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIX_W-1:0] out_pixel_value,
  input wire logic [POS_W-1:0] out_column,
  input wire logic [POS_W-1:0] out_row,
  input wire logic             out_burst_last,
  input wire logic             out_plane_done,
  input wire logic             out_overrun_error
);

  // an overrun item carries no sample and closes its burst
  `PRPD_ASSERT_NOW(a_ovr_zero, out_valid && out_overrun_error, out_pixel_value == '0 && out_column == '0 && out_row == '0 && out_burst_last)

  // end of plane comes only from a real sample
  `PRPD_ASSERT_NOW(a_done_not_ovr, out_valid && out_plane_done, !out_overrun_error)

  // a stalled result stays put
  `PRPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_value) && $stable(out_column) && $stable(out_row))

endmodule

bind planar_rle_plane_decoder_top prpd_chk u_prpd_chk (.*);

`default_nettype wire

// File: tb/sv/tb_planar_rle_plane_decoder_top.sv
// self-checking testbench for planar_rle_plane_decoder_top: control and raw bytes in,
// decoded samples out, compared against an in-bench plane decoder
// depends on prpd_pkg and planar_rle_plane_decoder_top
`timescale 1ns / 100ps

module tb_planar_rle_plane_decoder_top;
  import prpd_pkg::*;

  localparam int LINE_DEPTH    = 4096;
  localparam int ROW_LIMIT     = 4096;
  localparam int MAX_RUN       = 47;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 40;

  // one decoded sample as it leaves the block
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] rpt_row;
    logic             last;
    logic             done;
    logic             err;
  } sample_t;

  typedef enum logic {ROW_DATA, ROW_REG} row_kind_t;

  // directed stimulus row: a byte or a register write, optionally with a fixed result
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CNT_W-1:0]     val;
    logic [PIX_W-1:0]     code;
    logic                 typed;
    sample_t              want;
  } stim_row_t;

  typedef struct {
    int unsigned w;
    int unsigned h;
    bit          flip;
    int unsigned items;
    bit          complete;
  } phase_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_t;

  localparam sample_t NONE      = '0;
  localparam sample_t OVERRUN   = '{pix: '0, col: '0, rpt_row: '0, last: 1'b1, done: 1'b0,
                                    err: 1'b1};
  localparam sample_t FIRST_MAX = '{pix: 8'hFF, col: '0, rpt_row: '0, last: 1'b1,
                                    done: 1'b0, err: 1'b0};

  // directed part: reset config first, then a 4x2 flipped plane
  stim_row_t directed_tbl [26] = '{
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h00, 1'b0, NONE},       // empty control
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h10, 1'b0, NONE},       // one raw byte, no run
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'hFF, 1'b1, FIRST_MAX},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h03, 1'b0, NONE},       // short run repeats value
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h01, 1'b0, NONE},       // long run of 16
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h02, 1'b0, NONE},       // long run of 32
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'hF2, 1'b1, OVERRUN},    // run of 47 past the row end
    '{ROW_REG,  CFG_WIDTH,  13'd4, 8'h00, 1'b0, NONE},
    '{ROW_REG,  CFG_HEIGHT, 13'd2, 8'h00, 1'b0, NONE},
    '{ROW_REG,  CFG_FLIP,   13'd1, 8'h00, 1'b0, NONE},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h40, 1'b0, NONE},       // four absolute samples
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h00, 1'b0, NONE},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h80, 1'b0, NONE},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'hFF, 1'b0, NONE},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h7F, 1'b0, NONE},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h13, 1'b0, NONE},       // raw then run of deltas
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'hFE, 1'b0, NONE},       // largest positive delta
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h04, 1'b0, NONE},       // next plane, run of zeros
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h40, 1'b0, NONE},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h01, 1'b0, NONE},       // delta of -1
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'hFF, 1'b0, NONE},       // delta of -128
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h00, 1'b0, NONE},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'hFE, 1'b0, NONE},
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h12, 1'b1, OVERRUN},    // long run code too wide
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'hF0, 1'b1, OVERRUN},    // raw count too wide
    '{ROW_DATA, CFG_WIDTH,  13'd0, 8'h05, 1'b1, OVERRUN}     // short run too wide
  };

  // random phases; complete ones walk every row to the plane end
  phase_t phases [9] = '{
    '{5,    3,    1'b1, 50, 1'b1},
    '{0,    0,    1'b1, 20, 1'b0},
    '{47,   4,    1'b0, 50, 1'b0},
    '{64,   64,   1'b0, 60, 1'b0},
    '{100,  6,    1'b1, 50, 1'b1},
    '{13,   5,    1'b0, 50, 1'b1},
    '{2,    9,    1'b1, 40, 1'b0},
    '{8191, 1,    1'b1, 30, 1'b1},
    '{1,    8191, 1'b1, 20, 1'b0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_byte;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_pixel_value;
  logic [POS_W-1:0]     out_column;
  logic [POS_W-1:0]     out_row;
  logic                 out_burst_last;
  logic                 out_plane_done;
  logic                 out_overrun_error;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_wdata;

  planar_rle_plane_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_value  (out_pixel_value),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_burst_last   (out_burst_last),
    .out_plane_done   (out_plane_done),
    .out_overrun_error(out_overrun_error),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // decoder state mirrored in the bench
  logic [PIX_W-1:0] line_mem [LINE_DEPTH];
  int unsigned      col_pos, row_pos, raw_left, run_left;
  logic [PIX_W-1:0] run_val;
  logic [CNT_W-1:0] plane_w, plane_h;
  logic             flip_on;

  sample_t     pending_samples [$];
  int unsigned fail_count, bytes_sent, samples_checked, overruns_seen, planes_seen;
  int unsigned burst_left;

  function automatic int unsigned eff_w();
    if (plane_w == 0) return 1;
    if (plane_w > LINE_DEPTH) return LINE_DEPTH;
    return plane_w;
  endfunction

  function automatic int unsigned eff_h();
    if (plane_h == 0) return 1;
    if (plane_h > ROW_LIMIT) return ROW_LIMIT;
    return plane_h;
  endfunction

  function automatic void restart_plane();
    col_pos  = 0;
    row_pos  = 0;
    raw_left = 0;
    run_left = 0;
    run_val  = '0;
  endfunction

  // even codes add half, odd codes subtract half plus one
  function automatic logic [PIX_W-1:0] zigzag_delta(logic [PIX_W-1:0] b);
    return b[0] ? ~(b >> 1) : (b >> 1);
  endfunction

  // one sample: absolute on the first row, delta on the row above later
  function automatic void put_sample(bit is_raw, logic [PIX_W-1:0] b);
    sample_t          s;
    int unsigned      idx;
    logic [PIX_W-1:0] v;
    idx = col_pos % LINE_DEPTH;
    if (row_pos == 0) begin
      if (is_raw) run_val = b;
      v = run_val;
    end else begin
      if (is_raw) run_val = zigzag_delta(b);
      v = line_mem[idx] + run_val;
    end
    line_mem[idx] = v;
    s.pix     = v;
    s.col     = col_pos[POS_W-1:0];
    s.rpt_row = flip_on ? POS_W'(eff_h() - 1 - row_pos) : POS_W'(row_pos);
    s.last    = 1'b0;
    s.done    = 1'b0;
    s.err     = 1'b0;
    col_pos++;
    if (col_pos >= eff_w()) begin
      col_pos = 0;
      run_val = '0;
      row_pos++;
      if (row_pos >= eff_h()) begin
        row_pos = 0;
        s.done  = 1'b1;
      end
    end
    pending_samples.push_back(s);
  endfunction

  function automatic void drain_run();
    while (run_left > 0) begin
      put_sample(1'b0, '0);
      run_left--;
    end
  endfunction

  // all samples one accepted byte completes
  function automatic void decode_byte(logic [PIX_W-1:0] b);
    int unsigned n_prev, run_n, raw_n;
    n_prev = pending_samples.size();
    if (raw_left > 0) begin
      put_sample(1'b1, b);
      raw_left--;
      if (raw_left == 0) drain_run();
    end else begin
      run_n = b[3:0];
      raw_n = b[7:4];
      if (b[3:0] == RUN_CODE_16) begin
        run_n = RUN_BASE_16 + raw_n;
        raw_n = 0;
      end else if (b[3:0] == RUN_CODE_32) begin
        run_n = RUN_BASE_32 + raw_n;
        raw_n = 0;
      end
      if (col_pos + raw_n + run_n > eff_w()) begin
        pending_samples.push_back(OVERRUN);
        restart_plane();
      end else if (raw_n > 0) begin
        raw_left = raw_n;
        run_left = run_n;
      end else begin
        run_left = run_n;
        drain_run();
      end
    end
    if (pending_samples.size() > n_prev) pending_samples[pending_samples.size() - 1].last = 1'b1;
  endfunction

  // control byte for a pure run of 3 to 47
  function automatic logic [PIX_W-1:0] run_code(int unsigned n);
    if (n >= 32) return {4'(n - 32), RUN_CODE_32};
    if (n >= 16) return {4'(n - 16), RUN_CODE_16};
    return PIX_W'(n);
  endfunction

  // a control byte that fits in what is left of the row
  function automatic logic [PIX_W-1:0] pick_control(int unsigned rem);
    int unsigned kind, r, n, top;
    kind = $urandom_range(0, 15);
    if (kind == 0) return 8'h00;
    if (kind <= 5 && rem >= 16) begin
      top = (rem < MAX_RUN) ? rem : MAX_RUN;
      return run_code($urandom_range(16, top));
    end
    if (kind <= 8 && rem >= 3) begin
      top = (rem < 15) ? rem : 15;
      return run_code($urandom_range(3, top));
    end
    r = $urandom_range(1, (rem < 15) ? rem : 15);
    n = 0;
    if (rem - r >= 3 && $urandom_range(0, 1) == 1) begin
      top = (rem - r < 15) ? rem - r : 15;
      n = $urandom_range(3, top);
    end
    return {4'(r), 4'(n)};
  endfunction

  function automatic logic [PIX_W-1:0] rand_raw();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'hFE;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // send one item in bursts with random gaps, predict on acceptance
  task automatic push_byte(input logic [PIX_W-1:0] code, input logic typed, input sample_t want);
    int unsigned n_prev, gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= code;
    do @(posedge clk); while (in_ready !== 1'b1);
    burst_left--;
    bytes_sent++;
    n_prev = pending_samples.size();
    decode_byte(code);
    if (typed) begin
      while (pending_samples.size() > n_prev) void'(pending_samples.pop_back());
      pending_samples.push_back(want);
    end
  endtask

  // drop valid and let everything in flight drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_WIDTH:  plane_w = val;
      CFG_HEIGHT: plane_h = val;
      CFG_FLIP:   flip_on = val[0];
      default: ;
    endcase
  endtask

  // bring the decoder back to the start of a plane, by filling or by overrun
  task automatic finish_plane(input bit complete);
    int unsigned rem;
    while (row_pos != 0 || col_pos != 0 || raw_left != 0) begin
      rem = eff_w() - col_pos;
      if (raw_left > 0) push_byte(rand_raw(), 1'b0, NONE);
      else if (rem >= MAX_RUN || !complete) push_byte(run_code(MAX_RUN), 1'b0, NONE);
      else if (rem >= 3) push_byte(run_code(rem), 1'b0, NONE);
      else push_byte({4'(rem), 4'h0}, 1'b0, NONE);
    end
  endtask

  // receiver stalls, switching to a random pattern after a random hold
  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned ready_hold = 0;
  int unsigned ready_tick = 0;

  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_hold = $urandom_range(30, 200);
    end else begin
      ready_hold--;
    end
    ready_tick++;
    case (ready_mode)
      READY_ALWAYS:  out_ready <= 1'b1;
      READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
      READY_PATTERN: out_ready <= (ready_tick % 4 != 3);
      default:       out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // compare each accepted sample with the oldest expectation
  always @(posedge clk) begin : sample_check
    sample_t got, want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      got = {out_pixel_value, out_column, out_row, out_burst_last, out_plane_done,
             out_overrun_error};
      if (pending_samples.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected sample, expected none, actual %0h", $time, got);
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (want.err) overruns_seen++;
        if (want.done) planes_seen++;
        check_field("pixel_value", want.pix, got.pix);
        check_field("column", want.col, got.col);
        check_field("row", want.rpt_row, got.rpt_row);
        check_field("burst_last", want.last, got.last);
        check_field("plane_done", want.done, got.done);
        check_field("overrun_error", want.err, got.err);
      end
    end
  end

  initial begin : stimulus
    int unsigned k, p;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = CFG_WIDTH;
    cfg_wdata  = '0;
    plane_w    = 13'd64;
    plane_h    = 13'd64;
    flip_on    = 1'b0;
    burst_left = 0;
    restart_plane();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (k = 0; k < $size(directed_tbl); k++) begin
      if (directed_tbl[k].kind == ROW_REG) begin
        settle();
        write_reg(directed_tbl[k].idx, directed_tbl[k].val);
      end else begin
        push_byte(directed_tbl[k].code, directed_tbl[k].typed, directed_tbl[k].want);
      end
    end

    // random phases, each starting from the top of a plane
    for (p = 0; p < $size(phases); p++) begin
      settle();
      write_reg(CFG_WIDTH, CNT_W'(phases[p].w));
      write_reg(CFG_HEIGHT, CNT_W'(phases[p].h));
      write_reg(CFG_FLIP, CNT_W'(phases[p].flip));
      for (k = 0; k < phases[p].items; k++) begin
        if (raw_left > 0) push_byte(rand_raw(), 1'b0, NONE);
        else if ($urandom_range(0, 4) == 0) push_byte(PIX_W'($urandom_range(0, 255)), 1'b0, NONE);
        else push_byte(pick_control(eff_w() - col_pos), 1'b0, NONE);
      end
      finish_plane(phases[p].complete);
    end

    settle();
    $display("covered %0d bytes in %0d register phases: %0d samples, %0d overruns, %0d plane ends",
             bytes_sent, $size(phases) + 1, samples_checked, overruns_seen, planes_seen);
    $display("widths and heights from 1 to %0d, rows flipped and not", ROW_LIMIT);
    if (fail_count == 0 && pending_samples.size() == 0) begin
      $display("planar_rle_plane_decoder_top regression: pass");
    end else begin
      $display("planar_rle_plane_decoder_top regression: fail");
    end
    $finish;
  end

  // hard stop for a hung run
  initial begin
    #20_000_000;
    $display("planar_rle_plane_decoder_top regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/prpd_pkg.sv
hw/rtl/prpd_seq.sv
hw/rtl/prpd_pix.sv
hw/rtl/planar_rle_plane_decoder_top.sv
hw/rtl/prpd_chk.sv
tb/sv/tb_planar_rle_plane_decoder_top.sv
